>>> hw/rtl/iirtdf2_pkg.sv
`default_nettype none

package iirtdf2_pkg;

  // Fixed formats of the filter.
  localparam int ACC_BITS   = 40;
  localparam int COEF_BITS  = 18;
  localparam int CFG_ADDR_W = 3;
  localparam int TAP_W      = 2;
  // The 40-bit output y is multiplied in two halves of this many low bits.
  localparam int YLO_BITS   = 20;

  // Defaults for the top-level parameters.
  localparam int DEF_ORDER          = 2;
  localparam int DEF_SAMPLE_BITS    = 16;
  localparam int DEF_COEF_FRAC_BITS = 14;

  typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;
  typedef logic signed [COEF_BITS-1:0] coef_t;
  typedef logic signed [ACC_BITS-1:0] acc_t;

  // Register indexes of the configuration port.
  localparam cfg_addr_t REG_B0  = 3'd0;
  localparam cfg_addr_t REG_B1  = 3'd1;
  localparam cfg_addr_t REG_B2  = 3'd2;
  localparam cfg_addr_t REG_A1  = 3'd3;
  localparam cfg_addr_t REG_A2  = 3'd4;
  localparam cfg_addr_t REG_FIR = 3'd5;

  // b0 resets to 1.0 in Q3.14.
  localparam coef_t B0_RESET = 18'sd16384;

  // Saturation bounds of the accumulators.
  localparam acc_t ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

  typedef struct packed {
    coef_t b0;
    coef_t b1;
    coef_t b2;
    coef_t a1;
    coef_t a2;
    logic  fir_only;
  } coef_set_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_B0,
    S_Y,
    S_ADD,
    S_LO,
    S_HI,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    MUL_B,
    MUL_A_LO,
    MUL_A_HI
  } mul_op_t;

  typedef enum logic [2:0] {
    DP_NONE,
    DP_Y,
    DP_ADD,
    DP_LO,
    DP_HI
  } dp_op_t;

  typedef struct packed {
    logic             load;
    mul_op_t          mul_op;
    logic [TAP_W-1:0] tap;
    dp_op_t           dp_op;
    logic             out_load;
  } dp_cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/iirtdf2_regs.sv
`default_nettype none

module iirtdf2_regs (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         cfg_we,
  input  iirtdf2_pkg::cfg_addr_t      cfg_addr,
  input  wire [iirtdf2_pkg::COEF_BITS-1:0] cfg_wdata,
  output iirtdf2_pkg::coef_set_t      coef
);
  import iirtdf2_pkg::*;

  coef_set_t coef_r;
  coef_set_t coef_nxt;

  // Decode the register index; writes beyond the list are dropped.
  always_comb begin
    coef_nxt = coef_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_B0:  coef_nxt.b0 = $signed(cfg_wdata);
        REG_B1:  coef_nxt.b1 = $signed(cfg_wdata);
        REG_B2:  coef_nxt.b2 = $signed(cfg_wdata);
        REG_A1:  coef_nxt.a1 = $signed(cfg_wdata);
        REG_A2:  coef_nxt.a2 = $signed(cfg_wdata);
        REG_FIR: coef_nxt.fir_only = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.b0       <= B0_RESET;
      coef_r.b1       <= '0;
      coef_r.b2       <= '0;
      coef_r.a1       <= '0;
      coef_r.a2       <= '0;
      coef_r.fir_only <= 1'b0;
    end else begin
      coef_r <= coef_nxt;
    end
  end

  assign coef = coef_r;

endmodule

`default_nettype wire

>>> hw/rtl/iirtdf2_ctrl.sv
`default_nettype none

module iirtdf2_ctrl #(
  parameter int ORDER = iirtdf2_pkg::DEF_ORDER
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  wire                   out_tready,
  output iirtdf2_pkg::dp_cmd_t  cmd
);
  import iirtdf2_pkg::*;

  localparam logic [TAP_W-1:0] LAST_TAP = TAP_W'(ORDER);

  state_t           state_r;
  state_t           state_nxt;
  logic [TAP_W-1:0] tap_r;
  logic [TAP_W-1:0] tap_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             out_free;
  logic             accept;

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid_r || out_tready;
  assign accept   = in_tvalid && in_tready;

  // Next state and tap counter.
  always_comb begin
    state_nxt = state_r;
    tap_nxt   = tap_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_B0;
      end
      S_B0: state_nxt = S_Y;
      S_Y: begin
        state_nxt = S_ADD;
        tap_nxt   = TAP_W'(1);
      end
      S_ADD: state_nxt = S_LO;
      S_LO:  state_nxt = S_HI;
      S_HI: begin
        if (tap_r == LAST_TAP) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_ADD;
          tap_nxt   = tap_r + TAP_W'(1);
        end
      end
      S_DONE: begin
        if (out_free) state_nxt = accept ? S_B0 : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Ready and datapath commands for each state.
  always_comb begin
    in_tready    = 1'b0;
    cmd.mul_op   = MUL_B;
    cmd.tap      = '0;
    cmd.dp_op    = DP_NONE;
    cmd.out_load = 1'b0;
    unique case (state_r)
      S_IDLE: in_tready = 1'b1;
      S_B0: begin
        cmd.mul_op = MUL_B;
        cmd.tap    = '0;
      end
      S_Y: begin
        cmd.mul_op = MUL_B;
        cmd.tap    = TAP_W'(1);
        cmd.dp_op  = DP_Y;
      end
      S_ADD: begin
        cmd.mul_op = MUL_A_LO;
        cmd.tap    = tap_r;
        cmd.dp_op  = DP_ADD;
      end
      S_LO: begin
        cmd.mul_op = MUL_A_HI;
        cmd.tap    = tap_r;
        cmd.dp_op  = DP_LO;
      end
      S_HI: begin
        // Start the next tap's feed-forward product alongside the update.
        cmd.mul_op = MUL_B;
        cmd.tap    = tap_r + TAP_W'(1);
        cmd.dp_op  = DP_HI;
      end
      S_DONE: begin
        in_tready    = out_free;
        cmd.out_load = out_free;
      end
      default: ;
    endcase
    cmd.load = in_tvalid && in_tready;
  end

  // Output valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tap_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tap_r       <= tap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

>>> hw/rtl/iirtdf2_dp.sv
`default_nettype none

module iirtdf2_dp #(
  parameter int ORDER          = iirtdf2_pkg::DEF_ORDER,
  parameter int SAMPLE_BITS    = iirtdf2_pkg::DEF_SAMPLE_BITS,
  parameter int COEF_FRAC_BITS = iirtdf2_pkg::DEF_COEF_FRAC_BITS
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire signed [SAMPLE_BITS-1:0]  in_sample,
  input  wire                           in_block_start,
  input  iirtdf2_pkg::coef_set_t        coef,
  input  iirtdf2_pkg::dp_cmd_t          cmd,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  output logic                          out_saturated
);
  import iirtdf2_pkg::*;

  // Multiplier operand: a sample, or one half of y.
  localparam int MOP_W = (SAMPLE_BITS > YLO_BITS + 1) ? SAMPLE_BITS : YLO_BITS + 1;
  localparam int PW    = COEF_BITS + MOP_W;
  // Product plus delay.
  localparam int SUMW  = ((PW > ACC_BITS) ? PW : ACC_BITS) + 1;
  // Tap accumulator, scaled up by the fraction bits so feedback floors once.
  localparam int TW    = ((SUMW + COEF_FRAC_BITS > COEF_BITS + ACC_BITS) ?
                          SUMW + COEF_FRAC_BITS : COEF_BITS + ACC_BITS) + 1;
  localparam int SMP_HI = COEF_FRAC_BITS + SAMPLE_BITS - 1;
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  // All ones in the fraction bits: the final shift then rounds up, which
  // floors the subtracted feedback term instead of the whole difference.
  localparam logic signed [TW-1:0] CEIL_BIAS = TW'((1 << COEF_FRAC_BITS) - 1);

  logic signed [SAMPLE_BITS-1:0] x_r;
  logic signed [PW-1:0]          prod_r;
  logic signed [PW-1:0]          prod_nxt;
  acc_t                          y_r;
  logic signed [TW-1:0]          acc_r;
  acc_t                          d_r   [ORDER];
  acc_t                          d_nxt [ORDER];
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic                          sat_r;

  coef_t                         op_a;
  logic signed [MOP_W-1:0]       op_b;
  logic signed [SUMW-1:0]        sum;
  acc_t                          y_sat;
  logic signed [TW-1:0]          t_hi;
  logic signed [TW-1:0]          t_shr;
  acc_t                          d_new;
  logic                          y_fits;
  logic                          d_fits;
  logic                          s_fits;

  // Coefficient operand of the shared multiplier; feedback is zero in FIR mode.
  always_comb begin
    op_a = '0;
    if (cmd.mul_op == MUL_B) begin
      unique case (cmd.tap)
        2'd0:    op_a = coef.b0;
        2'd1:    op_a = coef.b1;
        2'd2:    op_a = coef.b2;
        default: op_a = '0;
      endcase
    end else if (!coef.fir_only) begin
      unique case (cmd.tap)
        2'd1:    op_a = coef.a1;
        2'd2:    op_a = coef.a2;
        default: op_a = '0;
      endcase
    end
  end

  // Data operand: the sample, the unsigned low half of y or the signed high half.
  always_comb begin
    unique case (cmd.mul_op)
      MUL_B:    op_b = MOP_W'(x_r);
      MUL_A_LO: op_b = MOP_W'($signed({1'b0, y_r[YLO_BITS-1:0]}));
      MUL_A_HI: op_b = MOP_W'($signed(y_r[ACC_BITS-1:YLO_BITS]));
      default:  op_b = '0;
    endcase
  end

  assign prod_nxt = op_a * op_b;

  // Product plus the head delay, saturated to the accumulator range for y.
  assign sum    = SUMW'(prod_r) + SUMW'(d_r[0]);
  assign y_fits = (&sum[SUMW-1:ACC_BITS-1]) || !(|sum[SUMW-1:ACC_BITS-1]);
  assign y_sat  = y_fits ? sum[ACC_BITS-1:0] : (sum[SUMW-1] ? ACC_MIN : ACC_MAX);

  // Last feedback half, then one floor shift and saturation of the new delay.
  assign t_hi   = acc_r - (TW'(prod_r) <<< YLO_BITS);
  assign t_shr  = t_hi >>> COEF_FRAC_BITS;
  assign d_fits = (&t_shr[TW-1:ACC_BITS-1]) || !(|t_shr[TW-1:ACC_BITS-1]);
  assign d_new  = d_fits ? t_shr[ACC_BITS-1:0] : (t_shr[TW-1] ? ACC_MIN : ACC_MAX);

  // Delays move toward the head: after y a zero enters, and each tap's
  // update enters at the tail, so the head always holds the next delay.
  always_comb begin
    for (int k = 0; k < ORDER; k++) d_nxt[k] = d_r[k];
    if (cmd.load && in_block_start) begin
      for (int k = 0; k < ORDER; k++) d_nxt[k] = '0;
    end else if (cmd.dp_op == DP_Y || cmd.dp_op == DP_HI) begin
      for (int k = 0; k < ORDER - 1; k++) d_nxt[k] = d_r[k+1];
      d_nxt[ORDER-1] = (cmd.dp_op == DP_HI) ? d_new : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ORDER; k++) d_r[k] <= '0;
    end else begin
      for (int k = 0; k < ORDER; k++) d_r[k] <= d_nxt[k];
    end
  end

  // Output sample: floor of y, saturated to the sample width.
  assign s_fits = (&y_r[ACC_BITS-1:SMP_HI]) || !(|y_r[ACC_BITS-1:SMP_HI]);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (cmd.load) x_r <= in_sample;
    unique case (cmd.dp_op)
      DP_Y:    y_r   <= y_sat;
      DP_ADD:  acc_r <= (TW'(sum) <<< COEF_FRAC_BITS) | CEIL_BIAS;
      DP_LO:   acc_r <= acc_r - TW'(prod_r);
      default: ;
    endcase
    if (cmd.out_load) begin
      sample_r <= s_fits ? $signed(y_r[SMP_HI:COEF_FRAC_BITS])
                         : (y_r[ACC_BITS-1] ? SMP_MIN : SMP_MAX);
      sat_r    <= !s_fits;
    end
  end

  assign out_sample    = sample_r;
  assign out_saturated = sat_r;

endmodule

`default_nettype wire

>>> hw/rtl/iir_transposed_direct_form2_core.sv
`default_nettype none

// Channel   Direction  Beat contents
// in_*      slave      tdata: sample_in; tuser: block_start
// out_*     master     tdata: sample_out; tuser: saturated
// cfg_*     write      cfg_addr selects b0, b1, b2, a1, a2, fir_only
//
// Each item runs through the one shared multiplier (18-bit coefficient
// operand) in order: b0*x, then per tap the b*x product and the two
// halves of a*y; the next beat is accepted only after the last tap update.
// In S_DONE a result goes into the output register that drives out_tvalid.
// A new beat is accepted while the previous result waits in the output
// register; only a result that finds that register full stalls the block.
// Reset (rst_n low, synchronous) clears the delays and loads b0 = 1.0.

module iir_transposed_direct_form2_core #(
  parameter int ORDER          = iirtdf2_pkg::DEF_ORDER,
  parameter int SAMPLE_BITS    = iirtdf2_pkg::DEF_SAMPLE_BITS,
  parameter int COEF_FRAC_BITS = iirtdf2_pkg::DEF_COEF_FRAC_BITS,
  parameter int DATA_W         = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire [DATA_W-1:0]                 in_tdata,   // sample_in
  input  wire                              in_tuser,   // block_start
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [DATA_W-1:0]                out_tdata,  // sample_out
  output logic                             out_tuser,  // saturated
  input  wire                              cfg_we,
  input  iirtdf2_pkg::cfg_addr_t           cfg_addr,
  input  wire [iirtdf2_pkg::COEF_BITS-1:0] cfg_wdata
);
  import iirtdf2_pkg::*;

  coef_set_t                     coef;
  dp_cmd_t                       cmd;
  logic signed [SAMPLE_BITS-1:0] out_sample;

  iirtdf2_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .coef      (coef)
  );

  iirtdf2_ctrl #(
    .ORDER (ORDER)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  iirtdf2_dp #(
    .ORDER          (ORDER),
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_sample      ($signed(in_tdata[SAMPLE_BITS-1:0])),
    .in_block_start (in_tuser),
    .coef           (coef),
    .cmd            (cmd),
    .out_sample     (out_sample),
    .out_saturated  (out_tuser)
  );

  // Sample in the low bits, zero fill above.
  assign out_tdata = DATA_W'($unsigned(out_sample));

  // An accepted beat always starts a computation that blocks the next one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted again right after an accept");

  // A result is only written into a free output register.
  a_out_free_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_tvalid || out_tready))
    else $error("result overwrote a pending output beat");

  // Each tap runs its three steps in order.
  a_tap_sequence: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.dp_op == DP_ADD |=> cmd.dp_op == DP_LO ##1 cmd.dp_op == DP_HI)
    else $error("tap step sequence broken");

endmodule

`default_nettype wire

>>> sim/testbench.sv
`default_nettype none

module testbench;
  import iirtdf2_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int CLK_PERIOD     = 2 * CLK_HALF;
  localparam int RESET_CYCLES   = 6;
  localparam int TIMEOUT_CYCLES = 300000;
  localparam int SAMPLE_W       = DEF_SAMPLE_BITS;
  localparam int FRAC_BITS      = DEF_COEF_FRAC_BITS;
  localparam int TAPS           = DEF_ORDER;
  localparam int IDLE_PCT       = 30;
  localparam int HOLD_LEN       = 300;
  localparam int SETTLE_CYCLES  = 12;
  localparam int RAND_SETTINGS  = 8;
  localparam int RAND_BEATS     = 105;
  localparam int MAX_REPORTS    = 10;

  // Register indexes past the last register; writes there must be dropped.
  localparam cfg_addr_t REG_SPARE_LO = 3'd6;
  localparam cfg_addr_t REG_SPARE_HI = 3'd7;

  localparam coef_t COEF_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};
  localparam coef_t COEF_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};

  typedef struct packed {
    logic                       start;
    logic signed [SAMPLE_W-1:0] sample;
  } in_beat_t;

  typedef struct packed {
    logic                clipped;
    logic [SAMPLE_W-1:0] value;
  } out_beat_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [SAMPLE_W-1:0]  in_tdata   = '0;
  logic                 in_tuser   = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [SAMPLE_W-1:0]  out_tdata;
  logic                 out_tuser;
  logic                 cfg_we     = 1'b0;
  cfg_addr_t            cfg_addr   = '0;
  logic [COEF_BITS-1:0] cfg_wdata  = '0;

  iir_transposed_direct_form2_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // sample_in
    .in_tuser  (in_tuser),   // block_start
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // sample_out
    .out_tuser (out_tuser),  // saturated
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // Filter state and coefficients as the testbench believes them to be.
  coef_t coef_b [0:2];
  coef_t coef_a [1:2];
  logic  fir_mode;
  acc_t  delay_line [0:TAPS-1];

  in_beat_t  pending_beats [$];
  out_beat_t filtered_q [$];

  in_beat_t  drive_beat;
  out_beat_t want_beat;
  out_beat_t got_beat;
  logic      in_fire     = 1'b0;
  logic      idle_on     = 1'b1;
  logic      hold_req    = 1'b0;
  int        hold_cycles = 0;

  int mismatch_count  = 0;
  int results_checked = 0;
  int clipped_results = 0;
  int block_starts    = 0;
  int settings_used   = 0;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  function automatic longint clamp(longint v, int bits);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // Transposed direct form II step: y = b0*x + d0, then each delay takes
  // b[i]*x + d[i] - floor(a[i]*y / 2^frac), all clamped to 40 bits.
  function automatic out_beat_t iir_predict(in_beat_t beat);
    longint    x;
    longint    y;
    longint    nxt;
    longint    fb;
    longint    s;
    int        i;
    out_beat_t r;
    x = longint'($signed(beat.sample));
    if (beat.start) begin
      for (i = 0; i < TAPS; i++) delay_line[i] = '0;
    end
    y = clamp(longint'(coef_b[0]) * x + longint'(delay_line[0]), ACC_BITS);
    for (i = 1; i <= TAPS; i++) begin
      nxt = (i < TAPS) ? longint'(delay_line[i]) : longint'(0);
      fb  = fir_mode ? longint'(0) : ((longint'(coef_a[i]) * y) >>> FRAC_BITS);
      delay_line[i-1] = acc_t'(clamp(longint'(coef_b[i]) * x + nxt - fb, ACC_BITS));
    end
    s = y >>> FRAC_BITS;
    r.clipped = (s != clamp(s, SAMPLE_W));
    r.value   = SAMPLE_W'(clamp(s, SAMPLE_W));
    return r;
  endfunction

  function automatic coef_t pick_coef(int span);
    case ($urandom_range(9))
      0:       return COEF_MAX;
      1:       return COEF_MIN;
      2:       return '0;
      default: return coef_t'(int'($urandom_range(2 * span)) - span);
    endcase
  endfunction

  function automatic in_beat_t random_beat();
    in_beat_t b;
    b.start = ($urandom_range(23) == 0);
    case ($urandom_range(9))
      0:       b.sample = {1'b0, {(SAMPLE_W-1){1'b1}}};
      1:       b.sample = {1'b1, {(SAMPLE_W-1){1'b0}}};
      2:       b.sample = SAMPLE_W'(int'($urandom_range(127)) - 64);
      default: b.sample = SAMPLE_W'($urandom);
    endcase
    return b;
  endfunction

  // Register write; the model copy is updated at the same time since the
  // filter is idle whenever this runs.
  task automatic write_reg(cfg_addr_t idx, logic [COEF_BITS-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_B0:  coef_b[0] = val;
      REG_B1:  coef_b[1] = val;
      REG_B2:  coef_b[2] = val;
      REG_A1:  coef_a[1] = val;
      REG_A2:  coef_a[2] = val;
      REG_FIR: fir_mode  = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_filter(coef_t b0, coef_t b1, coef_t b2, coef_t a1, coef_t a2,
                                logic fir);
    write_reg(REG_B0, b0);
    write_reg(REG_B1, b1);
    write_reg(REG_B2, b2);
    write_reg(REG_A1, a1);
    write_reg(REG_A2, a2);
    write_reg(REG_FIR, {{(COEF_BITS-1){1'b0}}, fir});
    settings_used++;
    @(posedge clk);
  endtask

  task automatic queue_beat(logic signed [SAMPLE_W-1:0] s, logic st);
    in_beat_t b;
    b.sample = s;
    b.start  = st;
    pending_beats.push_back(b);
  endtask

  // Wait until every queued beat went in and every result came back.
  task automatic wait_idle();
    while (pending_beats.size() != 0 || in_tvalid || filtered_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Sender: offers the next pending beat, holds it until it is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (pending_beats.size() != 0 && !(idle_on && $urandom_range(99) < IDLE_PCT)) begin
        drive_beat = pending_beats.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= drive_beat.sample;
        in_tuser  <= drive_beat.start;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_req && hold_cycles < HOLD_LEN) begin
      hold_cycles <= hold_cycles + 1;
      out_tready  <= 1'b0;
    end else begin
      out_tready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
    end
  end

  // Monitor: predict on every accepted input beat, check every output beat.
  always @(posedge clk) begin
    in_fire <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      if (in_tuser) block_starts++;
      filtered_q.push_back(iir_predict({in_tuser, in_tdata}));
    end
    if (rst_n && out_tvalid && out_tready) begin
      got_beat = {out_tuser, out_tdata};
      if (filtered_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected output beat: sample_out %0d saturated %0b",
                   $signed(got_beat.value), got_beat.clipped);
      end else begin
        want_beat = filtered_q.pop_front();
        results_checked++;
        if (got_beat.clipped) clipped_results++;
        if (got_beat.value !== want_beat.value || got_beat.clipped !== want_beat.clipped) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch on result %0d: sample_out exp %0d got %0d, saturated exp %0b got %0b",
                     results_checked, $signed(want_beat.value), $signed(got_beat.value),
                     want_beat.clipped, got_beat.clipped);
        end
      end
    end
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("timeout with %0d results still expected", filtered_q.size());
    $display("FAIL");
    $finish;
  end

  initial begin
    int       phase;
    int       n;
    int       b_span;
    int       a_span;
    in_beat_t beat;

    coef_b[0] = B0_RESET;
    coef_b[1] = '0;
    coef_b[2] = '0;
    coef_a[1] = '0;
    coef_a[2] = '0;
    fir_mode  = 1'b0;
    for (n = 0; n < TAPS; n++) delay_line[n] = '0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset coefficients give unity gain: input extremes pass straight through.
    queue_beat(16'sh7FFF, 1'b1);
    queue_beat(16'sh8000, 1'b0);
    queue_beat(16'sh0000, 1'b0);
    queue_beat(-16'sd1, 1'b0);
    queue_beat(16'sd1, 1'b0);
    wait_idle();

    // Writes to unused indexes are dropped; fir_only keeps only its low bit.
    write_reg(REG_SPARE_LO, {COEF_BITS{1'b1}});
    write_reg(REG_SPARE_HI, 18'h15555);
    write_reg(REG_FIR, {{(COEF_BITS-1){1'b1}}, 1'b0});
    @(posedge clk);
    queue_beat(-16'sd12345, 1'b0);
    queue_beat(16'sd23456, 1'b0);
    wait_idle();

    // Extreme gains clip the output in both directions.
    program_filter(COEF_MAX, COEF_MIN, COEF_MAX, '0, '0, 1'b0);
    queue_beat(16'sh7FFF, 1'b1);
    queue_beat(16'sh8000, 1'b0);
    queue_beat(16'sd12345, 1'b0);
    wait_idle();

    // Strong positive feedback runs the accumulators into saturation.
    program_filter(B0_RESET, '0, '0, COEF_MIN, COEF_MAX, 1'b0);
    queue_beat(16'sd30000, 1'b1);
    queue_beat(16'sd30000, 1'b0);
    queue_beat(-16'sd30000, 1'b0);
    queue_beat(16'sd30000, 1'b0);
    queue_beat(16'sh8000, 1'b0);
    queue_beat(16'sd0, 1'b0);
    wait_idle();

    // Same coefficients in FIR mode: the feedback must be ignored.
    write_reg(REG_FIR, {{(COEF_BITS-1){1'b0}}, 1'b1});
    @(posedge clk);
    queue_beat(16'sd20000, 1'b1);
    queue_beat(-16'sd20000, 1'b0);
    queue_beat(16'sh7FFF, 1'b0);
    queue_beat(16'sh8000, 1'b0);

    // Random settings, each followed by a run of random samples. One setting
    // runs without idling, another with a long output hold-off.
    for (phase = 0; phase < RAND_SETTINGS; phase++) begin
      wait_idle();
      idle_on = (phase != 3);
      if (phase == 5) hold_req = 1'b1;
      b_span = (phase % 2) ? 131071 : 16384;
      a_span = (phase % 2) ? 131071 : 12000;
      program_filter(pick_coef(b_span), pick_coef(b_span), pick_coef(b_span),
                     pick_coef(a_span), pick_coef(a_span), 1'($urandom_range(1)));
      for (n = 0; n < RAND_BEATS; n++) begin
        beat = random_beat();
        if (n == 0) beat.start = 1'b1;
        pending_beats.push_back(beat);
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    $display("Checked %0d filtered samples over %0d coefficient settings,",
             results_checked, settings_used);
    $display("with %0d clipped outputs and %0d block starts.", clipped_results, block_starts);
    if (mismatch_count == 0 && filtered_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_count, filtered_q.size());
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
hw/rtl/iirtdf2_pkg.sv
hw/rtl/iirtdf2_regs.sv
hw/rtl/iirtdf2_ctrl.sv
hw/rtl/iirtdf2_dp.sv
hw/rtl/iir_transposed_direct_form2_core.sv
sim/testbench.sv
